### rtl/gfrs_pkg.sv
`timescale 1ns / 1ps
package gfrs_pkg;
  localparam int ID_W = 6;
  localparam int BYTE_W = 27;
  localparam int CFG_W = 48;
  localparam int PCT_W = 7;
  localparam int WASTE_W = 16;
  localparam int REC_W = ID_W + 2 * BYTE_W;
  localparam int DIVD_W = 64;
  localparam int DIVS_W = 23;
  localparam int TOT_W = BYTE_W + 7;
  localparam int QCAP_W = 42;
  localparam int PCT_DIV = 100;
  localparam int THR_W = BYTE_W + PCT_W;

  // Capacity / 100 is (capacity >> 2) * RECIP_M >> 51, built from four partial products.
  localparam int HALF_W = 23;
  localparam int RECIP_W = 47;
  localparam int PP_W = 47;
  localparam int PROD_W = 93;
  localparam logic [RECIP_W-1:0] RECIP_M = 47'd90071992547410;

  typedef enum logic [2:0] {
    CFG_REGION_BYTES = 3'd0,
    CFG_GARB_THR_PCT = 3'd1,
    CFG_CAPACITY     = 3'd2,
    CFG_RESERVE_PCT  = 3'd3,
    CFG_WASTE_Q8     = 3'd4,
    CFG_MIN_FREE_PCT = 3'd5,
    CFG_ACTUAL_FREE  = 3'd6,
    CFG_UNUSED       = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic     ld;
    logic     run_init;
    logic     div_go;
    logic     min_go;
    logic     scan_init;
    logic     scan_rd;
    logic     eval;
    logic     fin;
  } gfrs_cmd_t;

  typedef struct packed {
    logic div_done;
    logic scan_end;
    logic pass_end;
    logic brk;
  } gfrs_sts_t;
endpackage

### rtl/gfrs_ram.sv
`timescale 1ns / 1ps
module gfrs_ram #(
  parameter int WIDTH = 60,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

### rtl/gfrs_div.sv
`timescale 1ns / 1ps
module gfrs_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         go,
  input  logic [gfrs_pkg::DIVD_W-1:0]  dividend,
  input  logic [gfrs_pkg::DIVS_W-1:0]  divisor,
  output logic                         done,
  output logic [gfrs_pkg::DIVD_W-1:0]  quotient
);
  import gfrs_pkg::*;

  logic [DIVD_W-1:0] quo_r;
  logic [DIVS_W-1:0] rem_r;
  logic [DIVS_W-1:0] dsr_r;
  logic [6:0]        cnt_r;
  logic              act_r;
  logic              done_r;
  logic [DIVS_W:0]   rem_sh;
  logic              ge;

  assign rem_sh = {rem_r, quo_r[DIVD_W-1]};
  assign ge = rem_sh >= {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        act_r <= 1'b1;
        cnt_r <= '0;
        quo_r <= dividend;
        rem_r <= '0;
        dsr_r <= divisor;
      end else if (act_r) begin
        rem_r <= ge ? DIVS_W'(rem_sh - {1'b0, dsr_r}) : rem_sh[DIVS_W-1:0];
        quo_r <= {quo_r[DIVD_W-2:0], ge};
        cnt_r <= cnt_r + 7'd1;
        if (cnt_r == 7'(DIVD_W - 1)) begin
          act_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quotient = quo_r;
endmodule

### rtl/gfrs_ctrl.sv
`timescale 1ns / 1ps
module gfrs_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                last,
  input  gfrs_pkg::gfrs_sts_t sts,
  output gfrs_pkg::gfrs_cmd_t cmd,
  output logic                busy
);
  import gfrs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_DIVW, S_MIN, S_SCAN, S_DRAIN, S_EVAL, S_FIN
  } state_t;

  state_t   state_r;
  logic     busy_r;
  logic     acc;

  assign acc = start && !busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (acc && last) begin
            state_r <= S_DIV;
            busy_r <= 1'b1;
          end
        end
        S_DIV: state_r <= S_DIVW;
        S_DIVW: begin
          if (sts.div_done) begin
            state_r <= S_MIN;
          end
        end
        S_MIN: state_r <= S_SCAN;
        S_SCAN: begin
          if (sts.scan_end) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: state_r <= S_EVAL;
        S_EVAL: state_r <= (sts.brk || sts.pass_end) ? S_FIN : S_SCAN;
        S_FIN: begin
          state_r <= S_IDLE;
          busy_r <= 1'b0;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd = '0;
    cmd.ld = acc;
    cmd.run_init = acc && last;
    cmd.div_go = (state_r == S_DIV);
    cmd.min_go = (state_r == S_MIN);
    cmd.scan_init = (state_r == S_MIN) || (state_r == S_EVAL);
    cmd.scan_rd = (state_r == S_SCAN);
    cmd.eval = (state_r == S_EVAL);
    cmd.fin = (state_r == S_FIN);
  end

  assign busy = busy_r;

  a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start && last))
    else $error("busy rose without a final transaction");
  a_fin_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) |=> !busy)
    else $error("busy held after end of run");
  a_ld_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ld |-> (state_r == S_IDLE))
    else $error("load outside idle");
endmodule

### rtl/gfrs_dp.sv
`timescale 1ns / 1ps
module gfrs_dp #(
  parameter int MAX_REGIONS = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  gfrs_pkg::gfrs_cmd_t           cmd,
  output gfrs_pkg::gfrs_sts_t           sts,
  input  logic                          cfg_we,
  input  logic [2:0]                    cfg_index,
  input  logic [gfrs_pkg::CFG_W-1:0]    cfg_data,
  input  logic [gfrs_pkg::ID_W-1:0]     in_region_id,
  input  logic [gfrs_pkg::BYTE_W-1:0]   in_live_bytes,
  input  logic [gfrs_pkg::BYTE_W-1:0]   in_garbage_bytes,
  output logic                          out_valid,
  output logic [gfrs_pkg::ID_W-1:0]     out_region_id_res,
  output logic                          out_selected,
  output logic                          out_last_res
);
  import gfrs_pkg::*;

  localparam int AW = $clog2(MAX_REGIONS);
  localparam int CW = $clog2(MAX_REGIONS + 1);

  logic [BYTE_W-1:0]  rb_r;
  logic [PCT_W-1:0]   gt_r, res_r, mf_r;
  logic [CFG_W-1:0]   cap_r, af_r;
  logic [WASTE_W-1:0] waste_r;

  logic [CFG_W+PCT_W-1:0]  p1_r;
  logic [THR_W-1:0]        p2_r;
  logic [QCAP_W+PCT_W-1:0] fmul_r;
  logic [DIVS_W-1:0]       dsr100_r;

  logic [DIVD_W-1:0] live_cap_r, min_g_r;

  logic              mact_r;
  logic [1:0]        mstep_r;
  logic [PROD_W-1:0] acc_r;

  logic [CW-1:0] cnt_r, pass_r;
  logic [AW-1:0] idx_r, rd_idx_r;
  logic          rd_vld_r;
  logic [MAX_REGIONS-1:0] done_r;

  logic              found_r;
  logic [ID_W-1:0]   best_id_r;
  logic [BYTE_W-1:0] best_live_r, best_garb_r;
  logic [AW-1:0]     best_idx_r;

  logic [TOT_W-1:0] lt_r, gt_tot_r;
  logic             pend_v_r;
  logic [ID_W-1:0]  pend_r;

  logic            ov_r, osel_r, olast_r;
  logic [ID_W-1:0] oid_r;

  logic [REC_W-1:0]  rdata;
  logic              div_done;
  logic [DIVD_W-1:0] div_q;
  logic [DIVD_W-1:0] free_t;
  logic [TOT_W-1:0]  new_live, new_garb;
  logic              take;
  logic [BYTE_W-1:0] rd_garb;
  logic [HALF_W-1:0] mx;
  logic [HALF_W:0]   mm;
  logic [PP_W-1:0]   pp;
  logic [PROD_W-1:0] pp_sh;
  logic [QCAP_W-1:0] qcap;
  logic [THR_W-1:0]  garb100;

  gfrs_ram #(.WIDTH(REC_W), .DEPTH(MAX_REGIONS)) u_ram (
    .clk(clk), .we(cmd.ld && (cnt_r < CW'(MAX_REGIONS))), .waddr(cnt_r[AW-1:0]),
    .wdata({in_region_id, in_live_bytes, in_garbage_bytes}),
    .raddr(idx_r), .rdata(rdata)
  );

  gfrs_div u_div (
    .clk(clk), .rst_n(rst_n), .go(cmd.div_go), .dividend(DIVD_W'({p1_r, 8'd0})),
    .divisor(dsr100_r), .done(div_done), .quotient(div_q)
  );

  always_comb begin
    mx = mstep_r[0] ? cap_r[CFG_W-1 -: HALF_W] : cap_r[HALF_W+1:2];
    mm = mstep_r[1] ? {1'b0, RECIP_M[RECIP_W-1:HALF_W+1]} : RECIP_M[HALF_W:0];
    pp = PP_W'(mx) * PP_W'(mm);
    unique case (mstep_r)
      2'd0: pp_sh = PROD_W'(pp);
      2'd1: pp_sh = PROD_W'(pp) << HALF_W;
      2'd2: pp_sh = PROD_W'(pp) << (HALF_W + 1);
      2'd3: pp_sh = PROD_W'(pp) << (2 * HALF_W + 1);
    endcase
  end

  assign qcap = acc_r[PROD_W-1 -: QCAP_W];
  assign free_t = DIVD_W'(fmul_r) + live_cap_r;
  assign rd_garb = rdata[BYTE_W-1:0];
  assign new_live = lt_r + TOT_W'(best_live_r);
  assign new_garb = gt_tot_r + TOT_W'(best_garb_r);
  assign garb100 = THR_W'(best_garb_r) * THR_W'(PCT_DIV);
  assign take = (DIVD_W'(new_garb) < min_g_r) || (garb100 > p2_r);

  always_comb begin
    sts.div_done = div_done;
    sts.scan_end = ({1'b0, idx_r} == CW'(cnt_r - CW'(1)));
    sts.pass_end = (pass_r == CW'(cnt_r - CW'(1)));
    sts.brk = DIVD_W'(new_live) > live_cap_r;
  end

  always_ff @(posedge clk) begin
    p1_r <= cap_r * res_r;
    p2_r <= rb_r * gt_r;
    fmul_r <= qcap * mf_r;
    dsr100_r <= DIVS_W'((waste_r == '0) ? WASTE_W'(1) : waste_r) * DIVS_W'(PCT_DIV);
    if (cmd.div_go) begin
      acc_r <= '0;
    end else if (mact_r) begin
      acc_r <= acc_r + pp_sh;
    end
    if (div_done) begin
      live_cap_r <= div_q;
    end
    if (cmd.min_go) begin
      min_g_r <= (free_t > DIVD_W'(af_r)) ? (free_t - DIVD_W'(af_r)) : '0;
    end
    rd_idx_r <= idx_r;
    if (rd_vld_r && !done_r[rd_idx_r] && (!found_r || rd_garb > best_garb_r)) begin
      best_id_r <= rdata[REC_W-1 -: ID_W];
      best_live_r <= rdata[2*BYTE_W-1 -: BYTE_W];
      best_garb_r <= rd_garb;
      best_idx_r <= rd_idx_r;
    end
    if (cmd.eval && !sts.brk && take) begin
      lt_r <= new_live;
      gt_tot_r <= new_garb;
      pend_r <= best_id_r;
    end else if (cmd.run_init) begin
      lt_r <= '0;
      gt_tot_r <= '0;
    end
    oid_r <= (cmd.eval && pend_v_r) ? pend_r : (pend_v_r ? pend_r : '0);
    osel_r <= pend_v_r;
    olast_r <= cmd.fin;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rb_r <= BYTE_W'(4194304);
      gt_r <= PCT_W'(25);
      cap_r <= '0;
      res_r <= PCT_W'(5);
      waste_r <= WASTE_W'(307);
      mf_r <= PCT_W'(10);
      af_r <= '0;
      mact_r <= 1'b0;
      mstep_r <= '0;
      cnt_r <= '0;
      pass_r <= '0;
      idx_r <= '0;
      rd_vld_r <= 1'b0;
      done_r <= '0;
      found_r <= 1'b0;
      pend_v_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_REGION_BYTES: rb_r <= cfg_data[BYTE_W-1:0];
          CFG_GARB_THR_PCT: gt_r <= cfg_data[PCT_W-1:0];
          CFG_CAPACITY:     cap_r <= cfg_data;
          CFG_RESERVE_PCT:  res_r <= cfg_data[PCT_W-1:0];
          CFG_WASTE_Q8:     waste_r <= cfg_data[WASTE_W-1:0];
          CFG_MIN_FREE_PCT: mf_r <= cfg_data[PCT_W-1:0];
          CFG_ACTUAL_FREE:  af_r <= cfg_data;
          default:          ;
        endcase
      end
      if (cmd.div_go) begin
        mact_r <= 1'b1;
        mstep_r <= '0;
      end else if (mact_r) begin
        mstep_r <= mstep_r + 2'd1;
        if (mstep_r == 2'd3) begin
          mact_r <= 1'b0;
        end
      end
      if (cmd.ld && (cnt_r < CW'(MAX_REGIONS))) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (cmd.fin) begin
        cnt_r <= '0;
      end
      rd_vld_r <= cmd.scan_rd;
      if (cmd.scan_init) begin
        idx_r <= '0;
        found_r <= 1'b0;
      end else begin
        if (cmd.scan_rd) begin
          idx_r <= idx_r + AW'(1);
        end
        if (rd_vld_r && !done_r[rd_idx_r]) begin
          found_r <= 1'b1;
        end
      end
      if (cmd.run_init) begin
        done_r <= '0;
        pass_r <= '0;
        pend_v_r <= 1'b0;
      end else if (cmd.eval && !sts.brk) begin
        done_r[best_idx_r] <= 1'b1;
        pass_r <= pass_r + CW'(1);
        if (take) begin
          pend_v_r <= 1'b1;
        end
      end
      ov_r <= cmd.fin || (cmd.eval && !sts.brk && take && pend_v_r);
    end
  end

  assign out_valid = ov_r;
  assign out_region_id_res = oid_r;
  assign out_selected = osel_r;
  assign out_last_res = olast_r;

  a_last_then_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_res |=> !out_valid)
    else $error("result after final result of run");
  a_unsel_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_selected |-> out_last_res)
    else $error("empty result that is not final");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_REGIONS))
    else $error("region count beyond store depth");
endmodule

### rtl/garbage_first_region_selector.sv
`timescale 1ns / 1ps
// Transactions load on start while busy is low; busy stays low until a transaction with last set.
// After that transaction busy stays high through the serial division in gfrs_div, then p passes
// over the n stored regions (p <= n), one RAM read per cycle.
// Results are strobed on out_valid one cycle each; the final one comes in the same cycle that busy falls.
// The receiver cannot stall. Synchronous active-low reset restores the register defaults.
module garbage_first_region_selector #(
  parameter int MAX_REGIONS = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [gfrs_pkg::ID_W-1:0]   in_region_id,
  input  logic [gfrs_pkg::BYTE_W-1:0] in_live_bytes,
  input  logic [gfrs_pkg::BYTE_W-1:0] in_garbage_bytes,
  input  logic                        in_last,
  output logic                        out_valid,
  output logic [gfrs_pkg::ID_W-1:0]   out_region_id_res,
  output logic                        out_selected,
  output logic                        out_last_res,
  input  logic                        cfg_we,
  input  logic [2:0]                  cfg_index,
  input  logic [gfrs_pkg::CFG_W-1:0]  cfg_data
);
  import gfrs_pkg::*;

  gfrs_cmd_t cmd;
  gfrs_sts_t sts;

  gfrs_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .last(in_last),
    .sts(sts), .cmd(cmd), .busy(busy)
  );

  gfrs_dp #(.MAX_REGIONS(MAX_REGIONS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_region_id(in_region_id), .in_live_bytes(in_live_bytes),
    .in_garbage_bytes(in_garbage_bytes),
    .out_valid(out_valid), .out_region_id_res(out_region_id_res),
    .out_selected(out_selected), .out_last_res(out_last_res)
  );
endmodule

### tb/garbage_first_region_selector_test.sv
`timescale 1ns / 1ps
module garbage_first_region_selector_test;
  import gfrs_pkg::*;

  localparam int STORE_DEPTH = 64;
  localparam longint unsigned BYTES_MAX = 64'd67108864;

  typedef struct {
    logic [ID_W-1:0]   id;
    logic [BYTE_W-1:0] live;
    logic [BYTE_W-1:0] garbage;
    logic              last;
  } region_item_t;

  typedef struct {
    logic [ID_W-1:0] id;
    logic            sel;
    logic            last;
  } choice_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [ID_W-1:0] in_region_id = '0;
  logic [BYTE_W-1:0] in_live_bytes = '0;
  logic [BYTE_W-1:0] in_garbage_bytes = '0;
  logic in_last = 1'b0;
  logic out_valid;
  logic [ID_W-1:0] out_region_id_res;
  logic out_selected;
  logic out_last_res;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  region_item_t pending_q[$];
  choice_t chosen_q[$];
  region_item_t store[STORE_DEPTH];
  int stored_n;
  int errors;
  int idle_pct;
  bit took;
  longint unsigned reg_val[7];

  garbage_first_region_selector u_dut (.*);

  always #5 clk = ~clk;

  task automatic report(input string what);
    $display("mismatch: %s", what);
    errors++;
  endtask

  function automatic void pick_collection_set();
    int order[STORE_DEPTH];
    int cur, j, k;
    longint unsigned waste, cset_cap, free_goal, garb_goal, thr, live_sum, garb_sum;
    longint unsigned nl, ng;
    choice_t c;
    for (int i = 0; i < stored_n; i++) order[i] = i;
    for (int i = 1; i < stored_n; i++) begin
      cur = order[i];
      j = i;
      while (j > 0 && store[order[j-1]].garbage < store[cur].garbage) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = cur;
    end
    waste = (reg_val[CFG_WASTE_Q8] == 0) ? 1 : reg_val[CFG_WASTE_Q8];
    cset_cap = (reg_val[CFG_CAPACITY] * reg_val[CFG_RESERVE_PCT] * 256) / (100 * waste);
    free_goal = (reg_val[CFG_CAPACITY] / 100) * reg_val[CFG_MIN_FREE_PCT] + cset_cap;
    garb_goal = (free_goal > reg_val[CFG_ACTUAL_FREE]) ?
                free_goal - reg_val[CFG_ACTUAL_FREE] : 0;
    thr = (reg_val[CFG_REGION_BYTES] * reg_val[CFG_GARB_THR_PCT]) / 100;
    live_sum = 0;
    garb_sum = 0;
    k = 0;
    for (int i = 0; i < stored_n; i++) begin
      nl = live_sum + store[order[i]].live;
      ng = garb_sum + store[order[i]].garbage;
      if (nl > cset_cap) break;
      if (ng < garb_goal || store[order[i]].garbage > thr) begin
        c.id = store[order[i]].id;
        c.sel = 1'b1;
        c.last = 1'b0;
        chosen_q.push_back(c);
        k++;
        live_sum = nl & 64'hFFFF_FFFF_FFFF;
        garb_sum = ng & 64'hFFFF_FFFF_FFFF;
      end
    end
    if (k == 0) begin
      c.id = '0;
      c.sel = 1'b0;
      c.last = 1'b1;
      chosen_q.push_back(c);
    end else begin
      chosen_q[chosen_q.size()-1].last = 1'b1;
    end
    stored_n = 0;
  endfunction

  always @(posedge clk) begin
    if (rst_n && start && !busy) begin
      took = 1'b1;
      if (stored_n < STORE_DEPTH) begin
        store[stored_n] = pending_q[0];
        stored_n++;
      end
      if (pending_q[0].last) pick_collection_set();
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (chosen_q.size() == 0) begin
        report($sformatf("unexpected result id=%0d", out_region_id_res));
      end else begin
        if (out_region_id_res !== chosen_q[0].id)
          report($sformatf("id got %0d want %0d", out_region_id_res, chosen_q[0].id));
        if (out_selected !== chosen_q[0].sel)
          report($sformatf("selected got %b want %b", out_selected, chosen_q[0].sel));
        if (out_last_res !== chosen_q[0].last)
          report($sformatf("last got %b want %b", out_last_res, chosen_q[0].last));
        void'(chosen_q.pop_front());
      end
    end
  end

  always @(negedge clk) begin
    if (took) begin
      void'(pending_q.pop_front());
      took = 1'b0;
    end
    if (rst_n && pending_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
      start <= 1'b1;
      in_region_id <= pending_q[0].id;
      in_live_bytes <= pending_q[0].live;
      in_garbage_bytes <= pending_q[0].garbage;
      in_last <= pending_q[0].last;
    end else begin
      start <= 1'b0;
    end
  end

  task automatic write_reg(input cfg_idx_t idx, input longint unsigned val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CFG_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    reg_val[idx] = val;
  endtask

  task automatic write_all(input longint unsigned rb, thr, cap, res, waste, mf, af);
    write_reg(CFG_REGION_BYTES, rb);
    write_reg(CFG_GARB_THR_PCT, thr);
    write_reg(CFG_CAPACITY, cap);
    write_reg(CFG_RESERVE_PCT, res);
    write_reg(CFG_WASTE_Q8, waste);
    write_reg(CFG_MIN_FREE_PCT, mf);
    write_reg(CFG_ACTUAL_FREE, af);
  endtask

  task automatic wait_idle();
    do @(posedge clk); while (pending_q.size() > 0 || start || chosen_q.size() > 0 || busy);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [BYTE_W-1:0] rand_bytes();
    case ($urandom_range(4))
      0: return BYTE_W'($urandom_range(0, 3) * 1000000);
      1: return BYTE_W'($urandom_range(0, 32'(BYTES_MAX)));
      2: return BYTE_W'(BYTES_MAX);
      3: return BYTE_W'($urandom_range(0, 1 << 20));
      default: return BYTE_W'($urandom_range(0, 1 << 24));
    endcase
  endfunction

  task automatic add_item(input int id, input longint unsigned lv, gb, input bit lst);
    region_item_t it;
    it.id = ID_W'(id);
    it.live = BYTE_W'(lv);
    it.garbage = BYTE_W'(gb);
    it.last = lst;
    pending_q.push_back(it);
  endtask

  task automatic add_run(input int n);
    for (int i = 0; i < n; i++)
      add_item($urandom_range(63), rand_bytes(), rand_bytes(), i == n - 1);
  endtask

  function automatic longint unsigned rand48();
    return {$urandom, $urandom} & 64'hFFFF_FFFF_FFFF;
  endfunction

  initial begin
    int sent;
    int n;
    errors = 0;
    stored_n = 0;
    took = 1'b0;
    idle_pct = 0;
    reg_val[CFG_REGION_BYTES] = 4194304;
    reg_val[CFG_GARB_THR_PCT] = 25;
    reg_val[CFG_CAPACITY] = 0;
    reg_val[CFG_RESERVE_PCT] = 5;
    reg_val[CFG_WASTE_Q8] = 307;
    reg_val[CFG_MIN_FREE_PCT] = 10;
    reg_val[CFG_ACTUAL_FREE] = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    add_item(0, 0, BYTES_MAX, 1'b0);
    add_item(63, BYTES_MAX, 0, 1'b0);
    add_item(5, 0, 1048576, 1'b1);
    add_item(9, 100, 0, 1'b1);
    wait_idle();

    write_all(BYTES_MAX, 0, 64'hFFFF_FFFF_FFFF, 100, 256, 100, 0);
    add_item(1, 1000, 5000, 1'b0);
    add_item(2, 2000, 5000, 1'b0);
    add_item(3, BYTES_MAX, BYTES_MAX, 1'b0);
    add_item(4, 0, 0, 1'b1);
    wait_idle();

    write_all(1, 127, 1000000000, 127, 0, 127, 64'hFFFF_FFFF_FFFF);
    add_item(10, 500, 700, 1'b0);
    add_item(11, 600, 700, 1'b0);
    add_item(12, 0, 0, 1'b1);
    wait_idle();

    write_all(4194304, 25, 64'd40000000000, 20, 65535, 0, 0);
    add_item(20, 5, 9, 1'b1);
    for (int i = 0; i < 66; i++)
      add_item(i & 63, i * 1000, (i * 7919) % 100000, i == 65);
    wait_idle();

    sent = 0;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: idle_pct = 0;
        1: idle_pct = 73;
        2: idle_pct = 13;
        default: idle_pct = 0;
      endcase
      write_all($urandom_range(1, BYTES_MAX), $urandom_range(0, 127),
                ($urandom_range(3) == 0) ? rand48() : {$urandom_range(1, 15), $urandom},
                $urandom_range(0, 127), $urandom_range(0, 3) == 0 ? 256 :
                $urandom_range(0, 65535), $urandom_range(0, 127),
                ($urandom_range(1) == 0) ? 0 : rand48() >> $urandom_range(0, 20));
      while (sent < (ph + 1) * 12) begin
        n = ($urandom_range(15) == 0) ? $urandom_range(40, 64) : $urandom_range(1, 10);
        add_run(n);
        sent += n;
      end
      wait_idle();
    end

    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("tb: failure");
    $finish;
  end
endmodule
